/* rtl/sril_pkg.sv */
// ----------------------------------------------------------------------------
// sril_pkg: shared types and constants for the sorted insert/remove list
// Capacity, widths, operation and status codes, and the control bundle that
// is broadcast to every cell of the list.
// ----------------------------------------------------------------------------
package sril_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Broadcast to every cell on each accepted request
    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        t_value value;
    } t_cell_ctrl;

endpackage

/* rtl/sril_cell.sv */
// ----------------------------------------------------------------------------
// sril_cell: one position of the sorted list
// Holds one value, compares it with the broadcast operand and takes the
// operand, its left neighbour's value or its right neighbour's value.
// ----------------------------------------------------------------------------
module sril_cell (
    input  logic                 i_clk,
    input  sril_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_occupied,
    input  logic                 i_left_lt,
    input  sril_pkg::t_value     i_left_value,
    input  sril_pkg::t_value     i_right_value,
    output sril_pkg::t_value     o_value,
    output logic                 o_lt,
    output logic                 o_ge,
    output logic                 o_eq
);
    import sril_pkg::*;

    t_value r_value;
    t_value n_value;

    // Flag where this entry stands against the operand
    assign o_lt = i_occupied && (r_value < i_ctrl.value);
    assign o_ge = i_occupied && !(r_value < i_ctrl.value);
    assign o_eq = i_occupied && (r_value == i_ctrl.value);

    // Insert: open a gap at the first entry not below the operand.
    // Remove: close the gap from the first entry not below the operand.
    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins_en && !o_lt) begin
            n_value = i_left_lt ? i_ctrl.value : i_left_value;
        end else if (i_ctrl.rem_en && o_ge) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* rtl/sorted_insert_remove_list_core.sv */
// ----------------------------------------------------------------------------
// sorted_insert_remove_list_core: bounded ascending sorted list
// Insert, remove-one-equal and clear requests on a row of compare-and-shift
// cells; each request answers with status, smallest, largest and count.
// ----------------------------------------------------------------------------
// A request is taken on any clock edge where start is high; busy never rises,
// so one request may be issued every cycle. Its result appears on the output
// ports, marked by o_done, for the single cycle after the accepting edge and
// must be captured then. All cells compare against the operand and shift on
// the accepting edge, so the rate is one request a cycle. An insert into a
// full list returns ST_FULL and leaves it unchanged.
module sorted_insert_remove_list_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sril_pkg::MODE_W-1:0]   i_mode,
    input  sril_pkg::t_value              i_value,
    output logic                          o_done,
    output logic [sril_pkg::STATUS_W-1:0] o_status,
    output sril_pkg::t_value              o_head_value,
    output sril_pkg::t_value              o_tail_value,
    output logic [sril_pkg::COUNT_W-1:0]  o_count
);
    import sril_pkg::*;

    logic                accept;
    t_cell_ctrl          ctrl;
    t_value              cell_value [CAPACITY];
    logic [CAPACITY-1:0] occupied;
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] ge;
    logic [CAPACITY-1:0] eq;
    logic                full;
    logic                found;
    logic [CNT_W-1:0]    tail_ptr;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign found  = |eq;

    // Broadcast the operation to the row
    assign ctrl.ins_en = accept && (i_mode == MODE_INSERT) && !full;
    assign ctrl.rem_en = accept && (i_mode == MODE_REMOVE) && found;
    assign ctrl.value  = i_value;

    // Build the row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign occupied[g] = (CNT_W'(g) < r_count);

        sril_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occupied    (occupied[g]),
            .i_left_lt     ((g == 0) ? 1'b1 : lt[(g == 0) ? 0 : g - 1]),
            .i_left_value  (cell_value[(g == 0) ? 0 : g - 1]),
            .i_right_value (cell_value[(g == CAPACITY - 1) ? g : g + 1]),
            .o_value       (cell_value[g]),
            .o_lt          (lt[g]),
            .o_ge          (ge[g]),
            .o_eq          (eq[g])
        );
    end

    // Work out the new count and status
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        case (i_mode)
            MODE_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (found) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Hold count, status and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_done   <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count  <= n_count;
                r_status <= n_status;
            end
        end
    end

    // Read the summary from the updated row
    assign tail_ptr     = r_count - 1'b1;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_count      = COUNT_W'(r_count);
    assign o_head_value = (r_count != '0) ? cell_value[0] : '0;
    assign o_tail_value = (r_count != '0) ? cell_value[tail_ptr[IDX_W-1:0]] : '0;

    // The count never runs past the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Every accepted request strobes a result in the cycle after it
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("accepted request produced no result");

    // A refused insert reports full and leaves the count alone
    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == MODE_INSERT) && full)
        |=> (o_status == ST_FULL) && (r_count == CNT_W'(CAPACITY)))
        else $error("insert into full list not refused");

    // The smallest entry never sits above the largest entry
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_count != '0)) |-> (o_head_value <= o_tail_value))
        else $error("smallest entry above largest entry");

endmodule
